[rtl/mbd_pkg.sv]
// Shared types, constants and helpers of the mip chain box downsampler.
// Depends on nothing; every other file of the block imports it.
package mbd_pkg;

  localparam int unsigned DEF_MAX_DIM      = 4096;
  localparam int unsigned DEF_MAX_LEVELS   = 12;
  localparam int unsigned DEF_MAX_CHANNELS = 4;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 9;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned LVL_OUT_W = 4;
  localparam int unsigned POS_OUT_W = 11;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd256;
  localparam logic [CNT_W-1:0] RST_CHAN   = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH     = 2'd0,
    REG_SRC_HEIGHT    = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_CLEAR_BORDERS = 2'd3
  } cfg_reg_e;

  // Position and border decision of one produced pixel.
  typedef struct packed {
    logic [LVL_OUT_W-1:0] level;
    logic [POS_OUT_W-1:0] x;
    logic [POS_OUT_W-1:0] y;
    logic                 border;
  } res_meta_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [LVL_OUT_W-1:0]    level;
    logic [POS_OUT_W-1:0]    x;
    logic [POS_OUT_W-1:0]    y;
    logic [NUM_CH*PIX_W-1:0] pix;
    logic                    last;
  } result_t;

  // Index of the highest set bit, zero for zero.
  function automatic logic [3:0] dim_msb(logic [DIM_W-1:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < DIM_W; i++) begin
      if (v[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/mbd_lane.sv]
// One channel lane: pair sum and rounded 2x2 or 2x1 mean of one channel.
// Depends on mbd_pkg.
module mbd_lane import mbd_pkg::*; (
  input  logic [PIX_W-1:0] held_i,
  input  logic [PIX_W-1:0] cur_i,
  input  logic [SUM_W-1:0] row_sum_i,
  input  logic             two_d_i,
  output logic [SUM_W-1:0] pair_o,
  output logic [PIX_W-1:0] avg_o
);

  logic [SUM_W+1:0] quad;
  logic [SUM_W:0]   duo;

  assign pair_o = SUM_W'(held_i) + SUM_W'(cur_i);
  assign quad   = (SUM_W+2)'(row_sum_i) + (SUM_W+2)'(pair_o) + (SUM_W+2)'(2);
  assign duo    = (SUM_W+1)'(pair_o) + (SUM_W+1)'(1);

  always_comb begin
    if (two_d_i) begin
      avg_o = quad[PIX_W+1:2];
    end else begin
      avg_o = duo[PIX_W:1];
    end
  end

endmodule

[rtl/mbd_merge.sv]
// Merging stage: gathers the lane means into one result and applies border zeroing.
// Depends on mbd_pkg.
module mbd_merge import mbd_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  res_meta_t                     meta_i,
  input  logic [MAX_CHANNELS*PIX_W-1:0] avg_i,
  output result_t                       res_o
);

  always_comb begin
    res_o       = '0;
    res_o.level = meta_i.level;
    res_o.x     = meta_i.x;
    res_o.y     = meta_i.y;
    if (!meta_i.border) begin
      res_o.pix[MAX_CHANNELS*PIX_W-1:0] = avg_i;
    end
  end

endmodule

[rtl/mipmap_box_downsampler.sv]
// Top level of the mip chain builder with a 2x2 box filter.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | sink      | in_valid_i/in_ready_o  | in_c0_i..in_c3_i
//   out     | source    | out_valid_o/out_ready_i| out_level_o, out_x_o, out_y_o,
//           |           |                        | out_c0_o..out_c3_o, last_of_run_o
//   cfg     | sink      | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// An item is accepted in ST_IDLE; the sequencer then visits ST_LOOK once for each level it
// walks (one per produced pixel plus the level where the walk stops), ST_CALC once per
// produced pixel, and ST_END once to close the item. The shared sequencer walks the
// levels one by one, with the registered read of the row pair store.
// Reset puts every position counter at zero and the configuration registers at their defaults.
// A stalled output holds the sequencer when a new pixel has to be handed over.
// A configuration write restarts the frame.
module mipmap_box_downsampler import mbd_pkg::*; #(
  parameter int unsigned MAX_DIM      = DEF_MAX_DIM,
  parameter int unsigned MAX_LEVELS   = DEF_MAX_LEVELS,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     in_c0_i,
  input  logic [PIX_W-1:0]     in_c1_i,
  input  logic [PIX_W-1:0]     in_c2_i,
  input  logic [PIX_W-1:0]     in_c3_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LVL_OUT_W-1:0] out_level_o,
  output logic [POS_OUT_W-1:0] out_x_o,
  output logic [POS_OUT_W-1:0] out_y_o,
  output logic [PIX_W-1:0]     out_c0_o,
  output logic [PIX_W-1:0]     out_c1_o,
  output logic [PIX_W-1:0]     out_c2_o,
  output logic [PIX_W-1:0]     out_c3_o,
  output logic                 last_of_run_o
);

  // The registers are 13 bits wide, so no dimension ever exceeds 8191.
  localparam int unsigned EFF_DIM = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int unsigned POS_W   = $clog2(EFF_DIM);
  localparam int unsigned LVL_W   = $clog2(MAX_LEVELS + 1);
  localparam int unsigned HLD_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LANE_W  = MAX_CHANNELS * PIX_W;
  localparam int unsigned ROW_W   = MAX_CHANNELS * SUM_W;
  localparam int unsigned XW      = DIM_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_CALC = 4'b0100,
    ST_END  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DIM_W-1:0] width_q, height_q;
  logic [CNT_W-1:0] chan_q;
  logic             clear_q;

  // Effective geometry and chain depth, derived from the registers.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] nch;
  logic [3:0]       msb_w, msb_h, msb_max;
  logic [LVL_W-1:0] nlev;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_q) > EFF_DIM) begin
      w_eff = DIM_W'(EFF_DIM);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_q) > EFF_DIM) begin
      h_eff = DIM_W'(EFF_DIM);
    end else begin
      h_eff = height_q;
    end
    if (chan_q == '0) begin
      nch = CNT_W'(1);
    end else if (32'(chan_q) > MAX_CHANNELS) begin
      nch = CNT_W'(MAX_CHANNELS);
    end else begin
      nch = chan_q;
    end
    msb_w   = dim_msb(w_eff);
    msb_h   = dim_msb(h_eff);
    msb_max = (msb_w > msb_h) ? msb_w : msb_h;
    if (32'(msb_max) > MAX_LEVELS) begin
      nlev = LVL_W'(MAX_LEVELS);
    end else begin
      nlev = LVL_W'(msb_max);
    end
  end

  // Per level walk state and stores.
  logic [POS_W-1:0]  col_q [MAX_LEVELS+1];
  logic [POS_W-1:0]  row_q [MAX_LEVELS+1];
  logic [LANE_W-1:0] held_q [MAX_LEVELS];
  logic [ROW_W-1:0]  row_mem [EFF_DIM];
  logic [ROW_W-1:0]  memrd_q;

  logic [LVL_W-1:0]  lvl_q;
  logic [POS_W-1:0]  off_q, off_nx_q;
  logic [LANE_W-1:0] cur_q;
  logic              two_d_q;
  res_meta_t         meta_q;
  result_t           pend_q;
  logic              pend_v_q;
  result_t           out_q;
  logic              out_valid_q;

  // Level step decode, evaluated while in ST_LOOK.
  logic [DIM_W-1:0] sw_raw, sh_raw, sw, sh, dw, dh;
  logic [POS_W-1:0] x, y, ox, oy, idx;
  logic [XW-1:0]    x_inc, y_inc;
  logic             at_end, two_d, in_box, odd_x, odd_y, pos_odd;
  logic             do_hold, do_row_wr, do_row_rd, do_calc, border;
  logic [LANE_W-1:0] held_rd;
  logic [LANE_W-1:0] avg_w;
  logic [ROW_W-1:0]  pair_w;
  logic [4*PIX_W-1:0] in_pix;
  logic [LANE_W-1:0] cur_in;
  result_t           new_res;
  result_t           last_res;
  logic              out_free;
  logic              out_load;

  assign held_rd = held_q[lvl_q[HLD_W-1:0]];
  assign in_pix  = {in_c3_i, in_c2_i, in_c1_i, in_c0_i};

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      cur_in[c*PIX_W +: PIX_W] = (c < 32'(nch)) ? in_pix[c*PIX_W +: PIX_W] : '0;
    end
  end

  always_comb begin
    sw_raw = w_eff >> lvl_q;
    sh_raw = h_eff >> lvl_q;
    sw     = (sw_raw == '0) ? DIM_W'(1) : sw_raw;
    sh     = (sh_raw == '0) ? DIM_W'(1) : sh_raw;
    dw     = ((sw_raw >> 1) == '0) ? DIM_W'(1) : (sw_raw >> 1);
    dh     = ((sh_raw >> 1) == '0) ? DIM_W'(1) : (sh_raw >> 1);
    x      = col_q[lvl_q];
    y      = row_q[lvl_q];
    x_inc  = XW'(x) + XW'(1);
    y_inc  = XW'(y) + XW'(1);
    at_end = (lvl_q >= nlev);
    two_d  = (sw > DIM_W'(1)) && (sh > DIM_W'(1));
    odd_x  = x[0];
    odd_y  = y[0];
    ox     = x >> 1;
    oy     = y >> 1;
    idx    = off_q + ox;
    do_hold   = 1'b0;
    do_row_wr = 1'b0;
    do_row_rd = 1'b0;
    if (two_d) begin
      in_box = (XW'(x) < {dw, 1'b0}) && (XW'(y) < {dh, 1'b0});
      pos_odd = odd_x;
      if (in_box && !at_end) begin
        do_hold   = !odd_x;
        do_row_wr = odd_x && !odd_y;
        do_row_rd = odd_x && odd_y;
      end
      do_calc = do_row_rd;
    end else begin
      if (sw > DIM_W'(1)) begin
        in_box  = XW'(x) < {dw, 1'b0};
        pos_odd = odd_x;
        oy      = '0;
      end else begin
        in_box  = XW'(y) < {dh, 1'b0};
        pos_odd = odd_y;
        ox      = '0;
      end
      if (in_box && !at_end) begin
        do_hold = !pos_odd;
      end
      do_calc = in_box && !at_end && pos_odd;
    end
    border = clear_q && ((dw < DIM_W'(3)) || (dh < DIM_W'(3)) || (ox == '0) || (oy == '0) ||
             ((XW'(ox) + XW'(1)) == XW'(dw)) || ((XW'(oy) + XW'(1)) == XW'(dh)));
  end

  // Channel lanes.
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    mbd_lane u_lane (
      .held_i    (held_rd[c*PIX_W +: PIX_W]),
      .cur_i     (cur_q[c*PIX_W +: PIX_W]),
      .row_sum_i (memrd_q[c*SUM_W +: SUM_W]),
      .two_d_i   (two_d_q),
      .pair_o    (pair_w[c*SUM_W +: SUM_W]),
      .avg_o     (avg_w[c*PIX_W +: PIX_W])
    );
  end

  mbd_merge #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_merge (
    .meta_i (meta_q),
    .avg_i  (avg_w),
    .res_o  (new_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // The held pixel leaves as a plain result from ST_CALC and as the closing one from
  // ST_END, where it carries the last flag.
  assign out_load = pend_v_q && out_free && ((state_q == ST_CALC) || (state_q == ST_END));

  always_comb begin
    last_res      = pend_q;
    last_res.last = 1'b1;
  end

  // Sequencer: one level per visit of ST_LOOK, a pixel computed in ST_CALC. The pixel
  // just made is kept back one step so that the last one of the item can be flagged.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = do_calc ? ST_CALC : ST_END;
      end
      ST_CALC: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_LOOK;
        end
      end
      ST_END: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= RST_WIDTH;
      height_q    <= RST_HEIGHT;
      chan_q      <= RST_CHAN;
      clear_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
      off_q       <= '0;
      for (int i = 0; i <= MAX_LEVELS; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SRC_WIDTH:     width_q  <= cfg_wdata_i;
          REG_SRC_HEIGHT:    height_q <= cfg_wdata_i;
          REG_CHANNEL_COUNT: chan_q   <= cfg_wdata_i[CNT_W-1:0];
          REG_CLEAR_BORDERS: clear_q  <= cfg_wdata_i[0];
          default: ;
        endcase
        for (int i = 0; i <= MAX_LEVELS; i++) begin
          col_q[i] <= '0;
          row_q[i] <= '0;
        end
      end else if (state_q == ST_LOOK) begin
        if (x_inc >= XW'(sw)) begin
          col_q[lvl_q] <= '0;
          row_q[lvl_q] <= (y_inc >= XW'(sh)) ? '0 : POS_W'(y_inc);
        end else begin
          col_q[lvl_q] <= POS_W'(x_inc);
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            lvl_q    <= '0;
            off_q    <= '0;
            pend_v_q <= 1'b0;
          end
        end
        ST_CALC: begin
          if (!pend_v_q || out_free) begin
            pend_v_q <= 1'b1;
            lvl_q    <= lvl_q + LVL_W'(1);
            off_q    <= off_nx_q;
          end
        end
        ST_END: begin
          if (pend_v_q && out_free) begin
            pend_v_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cur_q <= cur_in;
        end
      end
      ST_LOOK: begin
        two_d_q      <= two_d;
        off_nx_q     <= two_d ? POS_W'(off_q + POS_W'(dw)) : off_q;
        meta_q.level <= LVL_OUT_W'(lvl_q + LVL_W'(1));
        meta_q.x     <= POS_OUT_W'(ox);
        meta_q.y     <= POS_OUT_W'(oy);
        meta_q.border <= border;
        if (do_hold) begin
          held_q[lvl_q[HLD_W-1:0]] <= cur_q;
        end
        if (do_row_wr) begin
          row_mem[idx] <= pair_w;
        end
        if (do_row_rd) begin
          memrd_q <= row_mem[idx];
        end
      end
      ST_CALC: begin
        if (!pend_v_q || out_free) begin
          // A freshly merged result never has its last flag set.
          if (pend_v_q) begin
            out_q <= pend_q;
          end
          pend_q <= new_res;
          cur_q  <= avg_w;
        end
      end
      ST_END: begin
        if (pend_v_q && out_free) begin
          out_q <= last_res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_level_o   = out_q.level;
  assign out_x_o       = out_q.x;
  assign out_y_o       = out_q.y;
  assign out_c0_o      = out_q.pix[0*PIX_W +: PIX_W];
  assign out_c1_o      = out_q.pix[1*PIX_W +: PIX_W];
  assign out_c2_o      = out_q.pix[2*PIX_W +: PIX_W];
  assign out_c3_o      = out_q.pix[3*PIX_W +: PIX_W];
  assign last_of_run_o = out_q.last;

endmodule

[rtl/mbd_checker.sv]
// Port level checks of the mip chain builder, bound to the top level.
// Depends on mbd_pkg and mipmap_box_downsampler.
module mbd_checker import mbd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [LVL_OUT_W-1:0] out_level_o,
  input logic [POS_OUT_W-1:0] out_x_o,
  input logic                 last_of_run_o
);

  // An accepted item occupies the sequencer, so in_ready_o drops after each accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after accept");

  a_level_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_level_o != '0) else $error("result with level zero");

  // While idle, a waiting result can only be the closing one of its item.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_of_run_o) else $error("idle with open run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_level_o) && $stable(out_x_o))
    else $error("stalled result changed");

endmodule

bind mipmap_box_downsampler mbd_checker u_mbd_checker (.*);

[tb/tb_mipmap_box_downsampler.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the mip chain box downsampler.
// Depends on mbd_pkg and mipmap_box_downsampler; needs nothing else.
module tb_mipmap_box_downsampler;
  import mbd_pkg::*;

  localparam int unsigned DIM_LIMIT   = 4096;
  localparam int unsigned LEVEL_LIMIT = 12;
  localparam int unsigned CH_LIMIT    = 4;
  // Allow a healthy margin on top of the longest sequencer walk.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned TOTAL_PIXELS = 320;

  // One level-0 pixel waiting to be offered to the block.
  typedef struct {
    logic [PIX_W-1:0] ch[NUM_CH];
  } src_pix_t;

  // One mip pixel as the block should emit it.
  typedef struct {
    logic [LVL_OUT_W-1:0] level;
    logic [POS_OUT_W-1:0] x;
    logic [POS_OUT_W-1:0] y;
    logic [PIX_W-1:0]     ch[NUM_CH];
    logic                 last;
  } mip_pix_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     in_c0_i = '0;
  logic [PIX_W-1:0]     in_c1_i = '0;
  logic [PIX_W-1:0]     in_c2_i = '0;
  logic [PIX_W-1:0]     in_c3_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [LVL_OUT_W-1:0] out_level_o;
  logic [POS_OUT_W-1:0] out_x_o;
  logic [POS_OUT_W-1:0] out_y_o;
  logic [PIX_W-1:0]     out_c0_o;
  logic [PIX_W-1:0]     out_c1_o;
  logic [PIX_W-1:0]     out_c2_o;
  logic [PIX_W-1:0]     out_c3_o;
  logic                 last_of_run_o;

  mipmap_box_downsampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_c0_i       (in_c0_i),
    .in_c1_i       (in_c1_i),
    .in_c2_i       (in_c2_i),
    .in_c3_i       (in_c3_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_level_o   (out_level_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_c0_o      (out_c0_o),
    .out_c1_o      (out_c1_o),
    .out_c2_o      (out_c2_o),
    .out_c3_o      (out_c3_o),
    .last_of_run_o (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // Pixels still to be offered, and mip pixels still owed by the block.
  src_pix_t pixel_q[$];
  mip_pix_t expected_mips_q[$];

  int unsigned pixels_accepted = 0;
  int unsigned mips_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned frames_run = 0;
  bit          long_hold_req = 1'b0;

  // Shadow copy of the configuration registers.
  int unsigned shadow_width = 256;
  int unsigned shadow_height = 256;
  int unsigned shadow_chans = 4;
  bit          shadow_clear = 1'b0;

  // Shadow copy of the block's state. The pair store holds 9-bit sums of two pixels.
  int unsigned pair_sum_mem[DIM_LIMIT][NUM_CH];
  int unsigned held_pix[LEVEL_LIMIT][NUM_CH];
  int unsigned next_col[LEVEL_LIMIT+1];
  int unsigned next_row[LEVEL_LIMIT+1];

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic int unsigned level_size(int unsigned base, int unsigned lvl);
    int unsigned v;
    v = base >> lvl;
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i <= LEVEL_LIMIT; i++) begin
      next_col[i] = 0;
      next_row[i] = 0;
    end
  endfunction

  // Works out every mip pixel that one level-0 pixel completes, level by level,
  // and queues them. Each level feeds its fresh average into the next one.
  function automatic void predict_mips(src_pix_t px);
    int unsigned w, h, nch, nlev, s, off, x, y, sw, sh, dw, dh, ox, oy, idx, pos, lim;
    int unsigned cur[NUM_CH];
    int unsigned avg[NUM_CH];
    int unsigned pair[NUM_CH];
    bit made, border;
    mip_pix_t r;
    mip_pix_t run_q[$];
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    nch = (shadow_chans == 0) ? 1 : shadow_chans;
    if (nch > CH_LIMIT) nch = CH_LIMIT;
    nlev = 0;
    while (nlev < LEVEL_LIMIT && (level_size(w, nlev) > 1 || level_size(h, nlev) > 1))
      nlev++;
    for (int c = 0; c < NUM_CH; c++) begin
      cur[c] = (c < nch) ? px.ch[c] : 0;
      avg[c] = 0;
    end
    s = 0;
    off = 0;
    forever begin
      sw = level_size(w, s);
      sh = level_size(h, s);
      x = next_col[s];
      y = next_row[s];
      made = 1'b0;
      if (x + 1 >= sw) begin
        next_col[s] = 0;
        next_row[s] = (y + 1 >= sh) ? 0 : y + 1;
      end else begin
        next_col[s] = x + 1;
      end
      if (s >= nlev) break;
      dw = level_size(w, s + 1);
      dh = level_size(h, s + 1);
      ox = x >> 1;
      oy = y >> 1;
      if (sw > 1 && sh > 1) begin
        // Full 2x2 boxes: even rows park their pair sums, odd rows finish the box.
        if (x < 2 * dw && y < 2 * dh) begin
          if (x[0] == 1'b0) begin
            for (int c = 0; c < NUM_CH; c++) held_pix[s][c] = cur[c];
          end else begin
            idx = off + ox;
            for (int c = 0; c < NUM_CH; c++) pair[c] = held_pix[s][c] + cur[c];
            if (idx < DIM_LIMIT) begin
              if (y[0] == 1'b0) begin
                for (int c = 0; c < NUM_CH; c++) pair_sum_mem[idx][c] = pair[c];
              end else begin
                for (int c = 0; c < NUM_CH; c++)
                  avg[c] = (pair_sum_mem[idx][c] + pair[c] + 2) >> 2;
                made = 1'b1;
              end
            end
          end
        end
        off += dw;
      end else begin
        // One dimension has collapsed: average plain pixel pairs along the other.
        pos = (sw > 1) ? x : y;
        lim = (sw > 1) ? 2 * dw : 2 * dh;
        if (pos < lim) begin
          if (pos[0] == 1'b0) begin
            for (int c = 0; c < NUM_CH; c++) held_pix[s][c] = cur[c];
          end else begin
            for (int c = 0; c < NUM_CH; c++) avg[c] = (held_pix[s][c] + cur[c] + 1) >> 1;
            made = 1'b1;
          end
        end
        if (sw > 1) oy = 0;
        else ox = 0;
      end
      if (!made) break;
      border = shadow_clear && (dw < 3 || dh < 3 || ox == 0 || oy == 0 ||
                                ox + 1 == dw || oy + 1 == dh);
      r.level = LVL_OUT_W'(s + 1);
      r.x = POS_OUT_W'(ox);
      r.y = POS_OUT_W'(oy);
      for (int c = 0; c < NUM_CH; c++) r.ch[c] = border ? '0 : PIX_W'(avg[c]);
      r.last = 1'b0;
      run_q.push_back(r);
      for (int c = 0; c < NUM_CH; c++) cur[c] = avg[c];
      s++;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) expected_mips_q.push_back(run_q[i]);
  endfunction

  // Sender: offers queued pixels in bursts of random length separated by random gaps.
  // A pixel that is not yet taken stays on the port unchanged.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  src_pix_t    drive_pix;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        drive_pix.ch[0] = in_c0_i;
        drive_pix.ch[1] = in_c1_i;
        drive_pix.ch[2] = in_c2_i;
        drive_pix.ch[3] = in_c3_i;
        predict_mips(drive_pix);
        pixels_accepted++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          drive_pix = pixel_q.pop_front();
          in_c0_i <= drive_pix.ch[0];
          in_c1_i <= drive_pix.ch[1];
          in_c2_i <= drive_pix.ch[2];
          in_c3_i <= drive_pix.ch[3];
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            // New burst; a third of them run without any gap behind them.
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches at random between always ready, light and heavy stalling, and
  // honors a request for one long hold-off that it counts out itself.
  int unsigned stall_mode = 0;
  int unsigned mode_age = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (mode_age == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_age = 64;
      end
      mode_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 4) != 0);
          default: out_ready_i <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Checker: every accepted mip pixel is matched against the oldest one owed.
  mip_pix_t want;
  bit       field_bad;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mips_seen++;
      if (expected_mips_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected mip pixel: level %0d x %0d y %0d", out_level_o, out_x_o,
                   out_y_o);
      end else begin
        want = expected_mips_q.pop_front();
        field_bad = (want.level !== out_level_o) || (want.x !== out_x_o) ||
                    (want.y !== out_y_o) || (want.ch[0] !== out_c0_o) ||
                    (want.ch[1] !== out_c1_o) || (want.ch[2] !== out_c2_o) ||
                    (want.ch[3] !== out_c3_o) || (want.last !== last_of_run_o);
        if (field_bad) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected L%0d (%0d,%0d) %h %h %h %h last %0b,",
                     want.level, want.x, want.y, want.ch[0], want.ch[1], want.ch[2],
                     want.ch[3], want.last,
                     " got L%0d (%0d,%0d) %h %h %h %h last %0b",
                     out_level_o, out_x_o, out_y_o, out_c0_o,
                     out_c1_o, out_c2_o, out_c3_o, last_of_run_o);
        end
      end
    end
  end

  // Watchdog: any cycle without a handshake on either side counts toward the limit.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_mipmap_box_downsampler: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_W'(val);
    case (idx)
      REG_SRC_WIDTH:     shadow_width = val & 32'h1FFF;
      REG_SRC_HEIGHT:    shadow_height = val & 32'h1FFF;
      REG_CHANNEL_COUNT: shadow_chans = val & 32'h7;
      default:           shadow_clear = val[0];
    endcase
    restart_frame();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every pixel is taken and every owed mip pixel has come out, then lets
  // the sequencer finish any walk that produces nothing.
  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_valid_i || expected_mips_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Reconfigures the block and streams a number of pixels. With extremes set the
  // channels only take 0 or 255; otherwise they are random with an extreme now and then.
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned chans, bit clear,
                           int unsigned count, bit extremes);
    src_pix_t p;
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, chans);
    write_reg(REG_CLEAR_BORDERS, clear);
    for (int i = 0; i < count; i++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (extremes || $urandom_range(0, 7) == 0)
          p.ch[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else
          p.ch[c] = $urandom_range(0, 255);
      end
      pixel_q.push_back(p);
    end
    frames_run++;
    wait_drained();
  endtask

  int unsigned fw, fh, fcount;

  initial begin
    foreach (pair_sum_mem[i, c]) pair_sum_mem[i][c] = 0;
    foreach (held_pix[i, c]) held_pix[i][c] = 0;
    restart_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturated 4x4 image, a zero-size image that has no coarser level,
    // and a one-pixel-wide column with border clearing and an oversized channel count.
    run_frame(4, 4, 4, 1'b0, 16, 1'b1);
    run_frame(0, 0, 0, 1'b1, 2, 1'b1);
    run_frame(1, 8, 5, 1'b1, 8, 1'b1);

    // Geometry at and beyond the limit; these frames are cut short by the next write.
    run_frame(8191, 2, 7, 1'b0, 20, 1'b0);
    run_frame(1, 4096, 3, 1'b1, 20, 1'b0);
    run_frame(4096, 4096, 2, 1'b0, 20, 1'b0);

    // Fill an 8x8 image while the receiver holds off, so the block backs up.
    long_hold_req = 1'b1;
    run_frame(8, 8, 4, 1'b1, 64, 1'b0);

    // Random small frames, some run twice over to cover the wrap into a new frame.
    // The last one is trimmed so that the run offers the planned number of pixels.
    while (pixels_accepted < TOTAL_PIXELS) begin
      fw = $urandom_range(1, 10);
      fh = $urandom_range(1, 10);
      fcount = fw * fh * $urandom_range(1, 2);
      if (fcount > TOTAL_PIXELS - pixels_accepted) fcount = TOTAL_PIXELS - pixels_accepted;
      run_frame(fw, fh, $urandom_range(0, 7), $urandom_range(0, 1), fcount, 1'b0);
    end

    $display("covered %0d frames, %0d pixels in, %0d mip pixels out", frames_run,
             pixels_accepted, mips_seen);
    $display("settings ranged over clamped sizes, channel counts 0..7 and border clearing");
    if (mismatch_count == 0) begin
      $display("tb_mipmap_box_downsampler: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_mipmap_box_downsampler: errors");
    end
    $finish;
  end

endmodule

[mipmap_box_downsampler.f]
rtl/mbd_pkg.sv
rtl/mbd_lane.sv
rtl/mbd_merge.sv
rtl/mipmap_box_downsampler.sv
rtl/mbd_checker.sv
tb/tb_mipmap_box_downsampler.sv
